// File: design/epg_pkg.sv
package epg_pkg;

    // Field widths
    localparam int COORD_WIDTH = 16;
    localparam int INDEX_WIDTH = 16;
    localparam int ENTRY_W     = 32;
    localparam int DIST_W      = 24;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    // Fixed point: entries Q.24 times coordinates Q.4 give Q.28
    localparam int COORD_FRAC  = 4;
    localparam int ROUND_SHIFT = 12;   // Q.28 -> Q.16
    localparam int COMP_SHIFT  = 36;   // |component| limit, 256.0 in Q.28

    localparam int PROD_W = ENTRY_W + COORD_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MAG_W  = COMP_SHIFT - ROUND_SHIFT + 1;   // |q| <= 2^24
    localparam int Q_W    = MAG_W + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int ROOT_W = MAG_W;
    localparam int REM_W  = ROOT_W + 2;

    localparam logic [DIST_W-1:0]  DIST_MAX     = '1;
    localparam logic [ENTRY_W-1:0] ENTRY_ONE    = ENTRY_W'(32'h0100_0000);
    localparam logic [DIST_W-1:0]  RADIUS_RESET = DIST_W'(24'h01_0000);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROW0_X      = 3'd0,
        REG_ROW0_Y      = 3'd1,
        REG_ROW0_OFFSET = 3'd2,
        REG_ROW1_X      = 3'd3,
        REG_ROW1_Y      = 3'd4,
        REG_ROW1_OFFSET = 3'd5,
        REG_GATE_RADIUS = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic        [INDEX_WIDTH-1:0] point_index;
    } epg_in_t;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] result_index;
        logic                   inside_res;
        logic [DIST_W-1:0]      distance;
    } epg_out_t;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] row0_x;
        logic signed [ENTRY_W-1:0] row0_y;
        logic signed [ENTRY_W-1:0] row0_offset;
        logic signed [ENTRY_W-1:0] row1_x;
        logic signed [ENTRY_W-1:0] row1_y;
        logic signed [ENTRY_W-1:0] row1_offset;
    } epg_shape_t;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] index;
        logic                   sat;
        logic signed [Q_W-1:0]  u_q;
        logic signed [Q_W-1:0]  v_q;
    } epg_q_t;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] index;
        logic                   sat;
        logic [SQ_W-1:0]        sum_sq;
    } epg_sq_t;

    typedef struct packed {
        logic [INDEX_WIDTH-1:0] index;
        logic                   sat;
        logic [ROOT_W-1:0]      root;
    } epg_root_t;

endpackage

// File: design/ellipse_point_gate_core.sv
// Channel  | Ports                                    | Beat carries
// ---------+------------------------------------------+-------------------------------
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | register index, write data
// points   | s_valid, s_ready, s_payload               | point_x, point_y, point_index
// results  | m_valid, m_ready, m_payload               | result_index, inside_res, distance
//
// One point beat per clock sustained while m_ready is high; each result passes through
// 3 map stages, 2 square stages, 5 root stages of 5 bits each and the output register.
// The root stage count is set by the 25-bit root, resolved five bits per stage.
// Synchronous active-low reset empties the pipe and loads the identity shape, radius 1.0.
// Stalls ripple back stage by stage: empty stages keep filling while m_ready is low.
// cfg_ready is always high; write config only with the pipe empty.
module ellipse_point_gate_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [epg_pkg::CFG_ADDR_W-1:0]    cfg_index,
    input  logic [epg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  epg_pkg::epg_in_t                  s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output epg_pkg::epg_out_t                 m_payload
);
    import epg_pkg::*;

    // config registers
    epg_shape_t        shape_reg;
    logic [DIST_W-1:0] gate_radius_reg;

    // inter-block beats
    logic      q_valid, q_ready;
    epg_q_t    q_data;
    logic      sq_valid, sq_ready;
    epg_sq_t   sq_data;
    logic      rt_valid, rt_ready;
    epg_root_t rt_data;

    // output register
    logic      out_ready, out_load, over;
    logic      m_valid_reg;
    epg_out_t  m_payload_reg, m_payload_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg.row0_x      <= ENTRY_ONE;
            shape_reg.row0_y      <= '0;
            shape_reg.row0_offset <= '0;
            shape_reg.row1_x      <= '0;
            shape_reg.row1_y      <= ENTRY_ONE;
            shape_reg.row1_offset <= '0;
            gate_radius_reg       <= RADIUS_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROW0_X:      shape_reg.row0_x      <= ENTRY_W'(cfg_data);
                REG_ROW0_Y:      shape_reg.row0_y      <= ENTRY_W'(cfg_data);
                REG_ROW0_OFFSET: shape_reg.row0_offset <= ENTRY_W'(cfg_data);
                REG_ROW1_X:      shape_reg.row1_x      <= ENTRY_W'(cfg_data);
                REG_ROW1_Y:      shape_reg.row1_y      <= ENTRY_W'(cfg_data);
                REG_ROW1_OFFSET: shape_reg.row1_offset <= ENTRY_W'(cfg_data);
                REG_GATE_RADIUS: gate_radius_reg       <= cfg_data[DIST_W-1:0];
                default: ;   // unmapped index, write dropped
            endcase
        end
    end

    // map through the shape rows, round to Q.16
    epg_map u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .shape     (shape_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_payload),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // u^2 + v^2
    epg_square u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_data  (sq_data)
    );

    // floor square root, pipelined
    epg_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_data   (sq_data),
        .out_valid (rt_valid),
        .out_ready (rt_ready),
        .out_data  (rt_data)
    );

    // saturate and gate; a root with bit 24 set is beyond the Q8.16 range
    assign out_ready = !m_valid_reg || m_ready;
    assign rt_ready  = out_ready;
    assign out_load  = rt_valid && out_ready;
    assign over      = rt_data.sat || (rt_data.root[ROOT_W-1:DIST_W] != '0);

    always_comb begin
        m_payload_next.result_index = rt_data.index;
        m_payload_next.distance     = over ? DIST_MAX : rt_data.root[DIST_W-1:0];
        m_payload_next.inside_res   = !over && (rt_data.root[DIST_W-1:0] <= gate_radius_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= rt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTH
    a_inside_within_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (!m_payload.inside_res ||
                      (m_payload.distance <= $past(gate_radius_reg))))
        else $error("inside flag set with distance above radius");

    a_over_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && over) |=> ((m_payload.distance == DIST_MAX) && !m_payload.inside_res))
        else $error("out of range result not saturated");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");
`endif

endmodule

// File: design/epg_map.sv
module epg_map (
    input  logic                aclk,
    input  logic                aresetn,
    input  epg_pkg::epg_shape_t shape,
    input  logic                in_valid,
    output logic                in_ready,
    input  epg_pkg::epg_in_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output epg_pkg::epg_q_t     out_data
);
    import epg_pkg::*;

    localparam logic signed [SUM_W-1:0] HALF  = SUM_W'(1) <<< (ROUND_SHIFT - 1);
    localparam logic signed [SUM_W-1:0] LIMIT = SUM_W'(1) <<< COMP_SHIFT;
    // limits shifted by the rounding half already folded into the sum
    localparam logic signed [SUM_W-1:0] HI    = LIMIT + HALF;
    localparam logic signed [SUM_W-1:0] LO    = HALF - LIMIT;

    logic                     a_ready, b_ready, c_ready;
    logic                     a_valid_reg, b_valid_reg, c_valid_reg;
    logic [INDEX_WIDTH-1:0]   a_idx_reg, b_idx_reg;
    logic signed [PROD_W-1:0] a_ux_reg, a_uy_reg, a_vx_reg, a_vy_reg;
    logic signed [PROD_W-1:0] a_ux_next, a_uy_next, a_vx_next, a_vy_next;
    logic signed [SUM_W-1:0]  b_u_reg, b_v_reg, b_u_next, b_v_next;
    epg_q_t                   c_data_reg, c_data_next;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage A: four products
    assign a_ux_next = PROD_W'($signed(shape.row0_x)) * PROD_W'($signed(in_data.point_x));
    assign a_uy_next = PROD_W'($signed(shape.row0_y)) * PROD_W'($signed(in_data.point_y));
    assign a_vx_next = PROD_W'($signed(shape.row1_x)) * PROD_W'($signed(in_data.point_x));
    assign a_vy_next = PROD_W'($signed(shape.row1_y)) * PROD_W'($signed(in_data.point_y));

    // stage B: sums with offset and rounding half
    assign b_u_next = SUM_W'(a_ux_reg) + SUM_W'(a_uy_reg)
                    + (SUM_W'($signed(shape.row0_offset)) <<< COORD_FRAC) + HALF;
    assign b_v_next = SUM_W'(a_vx_reg) + SUM_W'(a_vy_reg)
                    + (SUM_W'($signed(shape.row1_offset)) <<< COORD_FRAC) + HALF;

    // stage C: range check and Q.16 result
    always_comb begin
        c_data_next.index = b_idx_reg;
        c_data_next.sat   = (b_u_reg >= HI) || (b_u_reg <= LO)
                         || (b_v_reg >= HI) || (b_v_reg <= LO);
        c_data_next.u_q   = Q_W'(b_u_reg >>> ROUND_SHIFT);
        c_data_next.v_q   = Q_W'(b_v_reg >>> ROUND_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_idx_reg <= in_data.point_index;
            a_ux_reg  <= a_ux_next;
            a_uy_reg  <= a_uy_next;
            a_vx_reg  <= a_vx_next;
            a_vy_reg  <= a_vy_next;
        end
        if (b_ready && a_valid_reg) begin
            b_idx_reg <= a_idx_reg;
            b_u_reg   <= b_u_next;
            b_v_reg   <= b_v_next;
        end
        if (c_ready && b_valid_reg) begin
            c_data_reg <= c_data_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

endmodule

// File: design/epg_square.sv
module epg_square (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  epg_pkg::epg_q_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output epg_pkg::epg_sq_t out_data
);
    import epg_pkg::*;

    logic                   d_ready, e_ready;
    logic                   d_valid_reg, e_valid_reg;
    logic [INDEX_WIDTH-1:0] d_idx_reg;
    logic                   d_sat_reg;
    logic [MAG_W-1:0]       u_mag, v_mag;
    logic [SQ_W-1:0]        d_usq_reg, d_vsq_reg, d_usq_next, d_vsq_next;
    epg_sq_t                e_data_reg, e_data_next;

    assign e_ready  = !e_valid_reg || out_ready;
    assign d_ready  = !d_valid_reg || e_ready;
    assign in_ready = d_ready;

    // stage D: magnitudes squared
    assign u_mag      = in_data.u_q[Q_W-1] ? MAG_W'(-in_data.u_q) : MAG_W'(in_data.u_q);
    assign v_mag      = in_data.v_q[Q_W-1] ? MAG_W'(-in_data.v_q) : MAG_W'(in_data.v_q);
    assign d_usq_next = SQ_W'(u_mag) * SQ_W'(u_mag);
    assign d_vsq_next = SQ_W'(v_mag) * SQ_W'(v_mag);

    // stage E: sum of squares, at most 2^49
    always_comb begin
        e_data_next.index  = d_idx_reg;
        e_data_next.sat    = d_sat_reg;
        e_data_next.sum_sq = d_usq_reg + d_vsq_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else begin
            if (d_ready) begin
                d_valid_reg <= in_valid;
            end
            if (e_ready) begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (d_ready && in_valid) begin
            d_idx_reg <= in_data.index;
            d_sat_reg <= in_data.sat;
            d_usq_reg <= d_usq_next;
            d_vsq_reg <= d_vsq_next;
        end
        if (e_ready && d_valid_reg) begin
            e_data_reg <= e_data_next;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_data  = e_data_reg;

endmodule

// File: design/epg_isqrt.sv
module epg_isqrt (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  epg_pkg::epg_sq_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output epg_pkg::epg_root_t out_data
);
    import epg_pkg::*;

    localparam int STEPS       = 5;
    localparam int SQRT_STAGES = (ROOT_W + STEPS - 1) / STEPS;

    typedef struct packed {
        logic [SQ_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_acc_t;

    // one restoring step: two radicand bits in, one root bit out
    function automatic sqrt_acc_t sqrt_step(input sqrt_acc_t a);
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        sqrt_acc_t        r;
        cur   = {a.rem, a.rad[SQ_W-1 -: 2]};
        trial = (REM_W + 2)'({a.root, 2'b01});
        r.rad = a.rad << 2;
        if (cur >= trial) begin
            r.rem  = REM_W'(cur - trial);
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = REM_W'(cur);
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic [SQRT_STAGES-1:0] st_valid_reg;
    logic [SQRT_STAGES-1:0] st_sat_reg;
    logic [SQRT_STAGES:0]   st_ready;
    logic [INDEX_WIDTH-1:0] st_idx_reg [SQRT_STAGES];
    sqrt_acc_t              st_acc_reg [SQRT_STAGES];

    assign st_ready[SQRT_STAGES] = out_ready;
    assign in_ready              = st_ready[0];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        logic                   src_valid;
        logic                   src_sat;
        logic [INDEX_WIDTH-1:0] src_idx;
        sqrt_acc_t              src_acc;
        sqrt_acc_t              acc_next;

        if (s == 0) begin : g_head
            assign src_valid    = in_valid;
            assign src_sat      = in_data.sat;
            assign src_idx      = in_data.index;
            assign src_acc.rad  = in_data.sum_sq;
            assign src_acc.rem  = '0;
            assign src_acc.root = '0;
        end else begin : g_body
            assign src_valid = st_valid_reg[s-1];
            assign src_sat   = st_sat_reg[s-1];
            assign src_idx   = st_idx_reg[s-1];
            assign src_acc   = st_acc_reg[s-1];
        end

        assign st_ready[s] = !st_valid_reg[s] || st_ready[s+1];

        always_comb begin
            acc_next = src_acc;
            for (int k = 0; k < STEPS; k++) begin
                if (s * STEPS + k < ROOT_W) begin
                    acc_next = sqrt_step(acc_next);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_valid_reg[s] <= 1'b0;
            end else if (st_ready[s]) begin
                st_valid_reg[s] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (st_ready[s] && src_valid) begin
                st_sat_reg[s] <= src_sat;
                st_idx_reg[s] <= src_idx;
                st_acc_reg[s] <= acc_next;
            end
        end
    end

    assign out_valid      = st_valid_reg[SQRT_STAGES-1];
    assign out_data.index = st_idx_reg[SQRT_STAGES-1];
    assign out_data.sat   = st_sat_reg[SQRT_STAGES-1];
    assign out_data.root  = st_acc_reg[SQRT_STAGES-1].root;

endmodule
